### rtl/core/gawq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gawq_pkg: shared types and constants for the group absmax quantizer
// Float constants, quantizer mode codes, result kinds, divider handshake
// structs and the fp32 to fp16 conversion.
// ----------------------------------------------------------------------------
package gawq_pkg;

  localparam int GROUP_LEN = 32;
  localparam int FILL_W    = $clog2(GROUP_LEN + 1);
  localparam int IDX_W     = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;

  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP_THREE = 32'h4040_0000;
  localparam logic [31:0] FP_SEVEN = 32'h40E0_0000;
  localparam logic [31:0] FP_INF   = 32'h7F80_0000;

  localparam logic [1:0] QT_INT4 = 2'd0;
  localparam logic [1:0] QT_INT3 = 2'd1;
  localparam logic [1:0] QT_INT2 = 2'd2;

  localparam logic KIND_SCALE = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  // fp32 to fp16, round half up, overflow to infinity
  function automatic logic [15:0] to_half(input logic [31:0] x);
    logic [15:0]       sgn;
    logic [7:0]        ef;
    logic signed [9:0] e;
    logic [23:0]       m;
    logic [4:0]        sh;
    logic [23:0]       hs;
    logic [15:0]       h;
    sgn = {x[31], 15'b0};
    ef  = x[30:23];
    e   = $signed({2'b00, ef}) - 10'sd112;
    m   = {1'b0, x[22:0]};
    sh  = '0;
    hs  = '0;
    if (ef == 8'hFF) begin
      h = sgn | 16'h7C00 | ((x[22:0] != 23'd0) ? 16'h0200 : 16'h0000);
    end else if (e >= 10'sd31) begin
      h = sgn | 16'h7C00;
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        h = sgn;
      end else begin
        m[23] = 1'b1;
        sh = 5'(10'sd14 - e);
        hs = m >> sh;
        h  = sgn | hs[15:0];
        if (m[sh - 5'd1]) h = h + 16'd1;
      end
    end else begin
      h = sgn | {1'b0, e[4:0], 10'b0} | {6'b0, m[22:13]};
      if (m[12]) h = h + 16'd1;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

### rtl/core/gawq_fdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gawq_fdiv: iterative fp32 divider
// Positive operands, one quotient bit per cycle, round to nearest even,
// subnormal results and overflow to infinity.
// ----------------------------------------------------------------------------
module gawq_fdiv
  import gawq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam logic [2:0] D_IDLE   = 3'd0;
  localparam logic [2:0] D_NORM   = 3'd1;
  localparam logic [2:0] D_DIV    = 3'd2;
  localparam logic [2:0] D_ALIGN  = 3'd3;
  localparam logic [2:0] D_DENORM = 3'd4;
  localparam logic [2:0] D_ROUND  = 3'd5;

  logic [2:0]         st_r;
  logic [23:0]        ma_r, mb_r, mt_r;
  logic signed [10:0] ea_r, eb_r, ex_r;
  logic [24:0]        rem_r;
  logic [25:0]        q_r;
  logic [4:0]         cnt_r;
  logic               g_r, s_r, done_r;
  logic [31:0]        quo_r;

  logic        qbit;
  logic [24:0] rem_sub;
  logic        inc;

  assign qbit    = (rem_r >= {1'b0, mb_r});
  assign rem_sub = qbit ? (rem_r - {1'b0, mb_r}) : rem_r;
  assign inc     = g_r & (s_r | mt_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (req.start) begin
            if (req.num[30:23] == 8'hFF) begin
              quo_r  <= FP_INF;
              done_r <= 1'b1;
            end else begin
              ma_r <= {req.num[30:23] != 8'd0, req.num[22:0]};
              mb_r <= {req.den[30:23] != 8'd0, req.den[22:0]};
              ea_r <= (req.num[30:23] == 8'd0) ? 11'sd1 : $signed({3'b0, req.num[30:23]});
              eb_r <= (req.den[30:23] == 8'd0) ? 11'sd1 : $signed({3'b0, req.den[30:23]});
              st_r <= D_NORM;
            end
          end
        end
        D_NORM: begin
          if (!ma_r[23]) begin
            ma_r <= {ma_r[22:0], 1'b0};
            ea_r <= ea_r - 11'sd1;
          end
          if (!mb_r[23]) begin
            mb_r <= {mb_r[22:0], 1'b0};
            eb_r <= eb_r - 11'sd1;
          end
          if (ma_r[23] && mb_r[23]) begin
            rem_r <= {1'b0, ma_r};
            q_r   <= '0;
            cnt_r <= '0;
            st_r  <= D_DIV;
          end
        end
        D_DIV: begin
          rem_r <= {rem_sub[23:0], 1'b0};
          q_r   <= {q_r[24:0], qbit};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd25) st_r <= D_ALIGN;
        end
        D_ALIGN: begin
          if (q_r[25]) begin
            mt_r <= q_r[25:2];
            g_r  <= q_r[1];
            s_r  <= q_r[0] | (rem_r != 25'd0);
            ex_r <= ea_r - eb_r + 11'sd127;
          end else begin
            mt_r <= q_r[24:1];
            g_r  <= q_r[0];
            s_r  <= (rem_r != 25'd0);
            ex_r <= ea_r - eb_r + 11'sd126;
          end
          st_r <= D_DENORM;
        end
        D_DENORM: begin
          // shift into the subnormal range one bit a cycle
          if (ex_r < 11'sd1) begin
            mt_r <= {1'b0, mt_r[23:1]};
            g_r  <= mt_r[0];
            s_r  <= s_r | g_r;
            ex_r <= ex_r + 11'sd1;
          end else begin
            st_r <= D_ROUND;
          end
        end
        D_ROUND: begin
          if (ex_r >= 11'sd255) begin
            quo_r <= FP_INF;
          end else begin
            quo_r <= {1'b0, (mt_r[23] ? ex_r[7:0] : 8'd0), mt_r[22:0]} + {31'd0, inc};
          end
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

### rtl/core/group_absmax_weight_quantizer.sv
`default_nettype none
// A group closes on its last request; the scale divide then runs (not for an
// all-zero group or in int2 mode), then the reciprocal divide (not for a zero
// or infinite scale), and each stored weight is read, normalised, multiplied
// and quantised. One request per cycle is taken while a group fills; the block is
// busy from group close until the group's final result enters the output register.
// Reset (rst_n low, synchronous) empties the group, clears packing state and mode.
// ----------------------------------------------------------------------------
// group_absmax_weight_quantizer: blockwise absmax int4/int3/int2 quantizer
// Buffers fp32 weights in groups, emits an fp16 scale per group followed by
// packed unsigned codes, LSB first, continuous across groups.
// ----------------------------------------------------------------------------
module group_absmax_weight_quantizer
  import gawq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // weight_bits
  input  wire logic        in_tlast,    // tensor_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // out_value
  output logic [1:0]       out_tuser,   // item_kind, tensor_end
  output logic             out_tlast,   // run_last
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data  // code width mode
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLOSE = 4'd1;
  localparam logic [3:0] S_WDIV1 = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_WDIV2 = 4'd4;
  localparam logic [3:0] S_INVN  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_LD    = 4'd7;
  localparam logic [3:0] S_WNORM = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_QNT   = 4'd10;
  localparam logic [3:0] S_FLUSH = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]         state_r;
  logic [1:0]         qt_r, qm_r;
  logic [FILL_W-1:0]  fill_r, idx_r;
  logic [31:0]        amax_r, scale_r, rd_r;
  logic               last_r;
  logic [23:0]        im_r, wm_r;
  logic signed [10:0] ie_r, we_r, pe_r;
  logic               inv_zero_r, inv_inf_r, wz_r, ws_r;
  logic [47:0]        prod_r;
  logic               pz_r, pinf_r, psign_r;
  logic [7:0]         pend_r;
  logic [2:0]         cnt_r;
  logic               stg_v_r, stg_kind_r;
  logic [15:0]        stg_val_r;
  logic               out_v_r, out_kind_r, out_rl_r, out_te_r;
  logic [15:0]        out_val_r;
  div_req_t           div_req_r;
  div_rsp_t           div_rsp;

  logic [31:0] mem [GROUP_LEN];

  logic        in_acc, out_free, can_push;
  logic [1:0]  qt_eff;
  logic [31:0] in_abs;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign can_push  = !stg_v_r || out_free;
  assign qt_eff    = (qt_r == QT_INT4 || qt_r == QT_INT3) ? qt_r : QT_INT2;
  assign in_abs    = {1'b0, in_tdata[30:0]};

  gawq_fdiv u_fdiv (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req_r),
    .rsp  (div_rsp)
  );

  // Group store: write on accept, registered read for the element pass
  always_ff @(posedge clk) begin
    if (in_acc) mem[fill_r[IDX_W-1:0]] <= in_tdata;
    if (state_r == S_RD) rd_r <= mem[idx_r[IDX_W-1:0]];
  end

  // Product rounding and quantisation of one element
  logic               p47, pinc, big;
  logic [23:0]        pm24;
  logic               pg, ps;
  logic [24:0]        pm25, f2;
  logic signed [10:0] xp1, nsh;
  logic [4:0]         mag, cl;
  logic [3:0]         qmax, bias, code, nbits;
  logic [11:0]        comb;
  logic [3:0]         ncnt;

  always_comb begin
    p47  = prod_r[47];
    pm24 = p47 ? prod_r[47:24] : prod_r[46:23];
    pg   = p47 ? prod_r[23] : prod_r[22];
    ps   = p47 ? (prod_r[22:0] != 23'd0) : (prod_r[21:0] != 22'd0);
    pinc = pg & (ps | pm24[0]);
    pm25 = {1'b0, pm24} + {24'd0, pinc};
    xp1  = pe_r + $signed({10'd0, p47}) + 11'sd1;
    nsh  = -xp1;
    big  = (xp1 >= 11'sd0);
    f2   = (big || nsh > 11'sd25) ? 25'd0 : (pm25 >> nsh[4:0]);
    if (pz_r) begin
      mag = 5'd0;
    end else if (pinf_r || big || f2 >= 25'd32) begin
      mag = 5'd16;
    end else begin
      mag = 5'(({1'b0, f2} + 26'd1) >> 1);
    end
    case (qm_r)
      QT_INT4: begin qmax = 4'd7; nbits = 4'd4; end
      QT_INT3: begin qmax = 4'd3; nbits = 4'd3; end
      default: begin qmax = 4'd1; nbits = 4'd2; end
    endcase
    bias = qmax + 4'd1;
    if (psign_r) begin
      cl   = (mag > {1'b0, bias}) ? {1'b0, bias} : mag;
      code = bias - cl[3:0];
    end else begin
      cl   = (mag > {1'b0, qmax}) ? {1'b0, qmax} : mag;
      code = bias + cl[3:0];
    end
    comb = {4'd0, pend_r} | ({8'd0, code} << cnt_r);
    ncnt = {1'b0, cnt_r} + nbits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      qt_r      <= QT_INT4;
      fill_r    <= '0;
      amax_r    <= '0;
      pend_r    <= '0;
      cnt_r     <= '0;
      stg_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      div_req_r <= '0;
    end else begin
      div_req_r.start <= 1'b0;
      if (cfg_wr_en) qt_r <= cfg_wr_data;
      // drop the output once taken; a push below overrides
      if (out_v_r && out_tready) out_v_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            fill_r <= fill_r + 1'b1;
            last_r <= in_tlast;
            // NaN patterns sit above infinity and never win
            if (in_abs > amax_r && in_abs <= FP_INF) amax_r <= in_abs;
            if (fill_r + 1'b1 == FILL_W'(GROUP_LEN) || in_tlast) state_r <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          qm_r <= qt_eff;
          if (amax_r == 32'd0) begin
            scale_r <= FP_ONE;
            state_r <= S_SCALE;
          end else if (qt_eff == QT_INT2) begin
            scale_r <= amax_r;
            state_r <= S_SCALE;
          end else begin
            div_req_r.start <= 1'b1;
            div_req_r.num   <= amax_r;
            div_req_r.den   <= (qt_eff == QT_INT4) ? FP_SEVEN : FP_THREE;
            state_r         <= S_WDIV1;
          end
        end
        S_WDIV1: begin
          if (div_rsp.done) begin
            scale_r <= div_rsp.quo;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (can_push) begin
            if (stg_v_r) begin
              out_v_r    <= 1'b1;
              out_kind_r <= stg_kind_r;
              out_val_r  <= stg_val_r;
              out_rl_r   <= 1'b0;
              out_te_r   <= 1'b0;
            end
            stg_v_r    <= 1'b1;
            stg_kind_r <= KIND_SCALE;
            stg_val_r  <= to_half(scale_r);
            // zero or infinite scale: reciprocal is taken as zero
            if (scale_r[30:0] == 31'd0 || scale_r[30:23] == 8'hFF) begin
              inv_zero_r <= 1'b1;
              inv_inf_r  <= 1'b0;
              im_r       <= '0;
              ie_r       <= '0;
              idx_r      <= '0;
              state_r    <= S_RD;
            end else begin
              div_req_r.start <= 1'b1;
              div_req_r.num   <= FP_ONE;
              div_req_r.den   <= scale_r;
              state_r         <= S_WDIV2;
            end
          end
        end
        S_WDIV2: begin
          if (div_rsp.done) begin
            inv_zero_r <= (div_rsp.quo[30:0] == 31'd0);
            inv_inf_r  <= (div_rsp.quo[30:23] == 8'hFF);
            im_r       <= {div_rsp.quo[30:23] != 8'd0, div_rsp.quo[22:0]};
            ie_r       <= (div_rsp.quo[30:23] == 8'd0) ? 11'sd1 :
                          $signed({3'b0, div_rsp.quo[30:23]});
            state_r    <= S_INVN;
          end
        end
        S_INVN: begin
          if (!inv_zero_r && !inv_inf_r && !im_r[23]) begin
            im_r <= {im_r[22:0], 1'b0};
            ie_r <= ie_r - 11'sd1;
          end else begin
            idx_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_LD;
        S_LD: begin
          wz_r    <= (rd_r[30:0] == 31'd0);
          ws_r    <= rd_r[31];
          wm_r    <= {rd_r[30:23] != 8'd0, rd_r[22:0]};
          we_r    <= (rd_r[30:23] == 8'd0) ? 11'sd1 : $signed({3'b0, rd_r[30:23]});
          state_r <= S_WNORM;
        end
        S_WNORM: begin
          if (!wz_r && !wm_r[23]) begin
            wm_r <= {wm_r[22:0], 1'b0};
            we_r <= we_r - 11'sd1;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= wm_r * im_r;
          pe_r    <= we_r + ie_r - 11'sd277;
          pz_r    <= wz_r | inv_zero_r;
          pinf_r  <= inv_inf_r & !wz_r;
          psign_r <= ws_r;
          state_r <= S_QNT;
        end
        S_QNT: begin
          if (ncnt >= 4'd8) begin
            if (can_push) begin
              if (stg_v_r) begin
                out_v_r    <= 1'b1;
                out_kind_r <= stg_kind_r;
                out_val_r  <= stg_val_r;
                out_rl_r   <= 1'b0;
                out_te_r   <= 1'b0;
              end
              stg_v_r    <= 1'b1;
              stg_kind_r <= KIND_BYTE;
              stg_val_r  <= {8'd0, comb[7:0]};
              pend_r     <= {4'd0, comb[11:8]};
              cnt_r      <= 3'(ncnt - 4'd8);
              idx_r      <= idx_r + 1'b1;
              state_r    <= (idx_r + 1'b1 == fill_r) ? S_FLUSH : S_RD;
            end
          end else begin
            pend_r  <= comb[7:0];
            cnt_r   <= ncnt[2:0];
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r + 1'b1 == fill_r) ? S_FLUSH : S_RD;
          end
        end
        S_FLUSH: begin
          if (last_r && cnt_r != 3'd0) begin
            if (can_push) begin
              if (stg_v_r) begin
                out_v_r    <= 1'b1;
                out_kind_r <= stg_kind_r;
                out_val_r  <= stg_val_r;
                out_rl_r   <= 1'b0;
                out_te_r   <= 1'b0;
              end
              stg_v_r    <= 1'b1;
              stg_kind_r <= KIND_BYTE;
              stg_val_r  <= {8'd0, pend_r};
              pend_r     <= '0;
              cnt_r      <= '0;
              state_r    <= S_DONE;
            end
          end else begin
            if (last_r) begin
              pend_r <= '0;
              cnt_r  <= '0;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // release the held result as the last of this group
          if (out_free) begin
            out_v_r    <= 1'b1;
            out_kind_r <= stg_kind_r;
            out_val_r  <= stg_val_r;
            out_rl_r   <= 1'b1;
            out_te_r   <= last_r;
            stg_v_r    <= 1'b0;
            fill_r     <= '0;
            amax_r     <= '0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = {out_te_r, out_kind_r};
  assign out_tlast  = out_rl_r;

  // Nothing is held back while new weights are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stg_v_r) else $error("staged result while accepting");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(GROUP_LEN)) else $error("group fill overrun");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WDIV1 || state_r == S_WDIV2))
    else $error("divider finished outside a wait state");

endmodule
`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for group_absmax_weight_quantizer
// Streams fp32 weights with tensor boundaries under every quantizer mode.
// A bit-true model of the block works out the scale and code bytes for each
// closed group, and every result is checked against it. Both stream sides
// idle at random, and one long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import gawq_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 600;
  localparam int SETTLE_CYC  = 80;

  typedef struct {
    logic        kind;
    logic [15:0] value;
    logic        run_last;
    logic        tensor_end;
  } quant_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;   // weight_bits
  logic        in_tlast    = 1'b0; // tensor_last
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // out_value
  logic [1:0]  out_tuser;          // item_kind, tensor_end
  logic        out_tlast;          // run_last
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = '0;   // code width mode

  // Model state of the block
  logic [31:0] grp_weights [GROUP_LEN];
  int          grp_count;
  logic [31:0] grp_amax;
  logic [15:0] pack_bits;
  int          pack_count;
  logic [1:0]  cur_mode;

  quant_result_t expected_results[$];
  int          error_count;
  int          idle_cycles;
  int          weights_sent;
  bit          rx_hold;
  bit          no_gaps;

  group_absmax_weight_quantizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Float helpers: arithmetic runs in double precision and is rounded to single
  // once per operation, which is exact for a single multiply or divide.
  // ---------------------------------------------------------------------------

  // Widen a single precision pattern to a real without loss
  function automatic real single_to_real(input logic [31:0] b);
    real r;
    if (b[30:23] == 8'h00) begin
      r = b[22:0] * 2.0 ** (-149);
      if (b[31]) r = -r;
    end else if (b[30:23] == 8'hFF) begin
      r = $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
    end else begin
      r = $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'b0});
    end
    return r;
  endfunction

  // Round a real to single precision, nearest even, with subnormals and overflow
  function automatic logic [31:0] real_to_single(input real r);
    logic [63:0] d;
    logic [52:0] sig;
    logic [52:0] kept;
    logic        rnd;
    logic        sticky;
    int          ex;
    int          sh;
    logic [31:0] res;
    d   = $realtobits(r);
    sig = {1'b1, d[51:0]};
    ex  = int'(d[62:52]) - 1023 + 127;
    res = {d[63], 31'b0};
    if (d[62:52] == 11'h7FF) begin
      res = {d[63], 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'h0};
    end else if (d[62:52] == 11'h000) begin
      res = {d[63], 31'b0};
    end else if (ex >= 1) begin
      kept   = sig >> 29;
      rnd    = sig[28];
      sticky = |sig[27:0];
      if (rnd && (sticky || kept[0])) kept = kept + 1;
      if (kept[24]) begin
        kept = kept >> 1;
        ex++;
      end
      if (ex >= 255) res = {d[63], 8'hFF, 23'h0};
      else           res = {d[63], 8'(ex), kept[22:0]};
    end else begin
      // subnormal single: unit is 2^-149
      sh = 29 + 1 - ex;
      if (sh <= 53) begin
        kept   = sig >> sh;
        rnd    = sig[sh - 1];
        sticky = (sig & ((53'd1 << (sh - 1)) - 53'd1)) != 0;
        if (rnd && (sticky || kept[0])) kept = kept + 1;
        res = {d[63], kept[30:0]};
      end
    end
    return res;
  endfunction

  // fp32 to fp16 with half-up rounding and overflow to infinity
  function automatic logic [15:0] half_of(input logic [31:0] x);
    logic [15:0] sgn;
    int          ex;
    logic [31:0] m;
    logic [31:0] h;
    int          sh;
    sgn = {x[31], 15'b0};
    ex  = int'(x[30:23]) - 112;
    m   = {9'b0, x[22:0]};
    if (x[30:23] == 8'hFF) return sgn | 16'h7C00 | ((m != 0) ? 16'h0200 : 16'h0);
    if (ex >= 31) return sgn | 16'h7C00;
    if (ex <= 0) begin
      if (ex < -10) return sgn;
      m  = m | 32'h0080_0000;
      sh = 14 - ex;
      h  = m >> sh;
      if ((m >> (sh - 1)) & 32'd1) h = h + 1;
      return sgn | h[15:0];
    end
    h = {16'b0, sgn} | (ex << 10) | (m >> 13);
    if (m[12]) h = h + 1;
    return h[15:0];
  endfunction

  // Round half away from zero, saturate and clamp to the code range
  function automatic int round_clamp(input logic [31:0] t, input int lo, input int hi);
    real a;
    int  m;
    if (t[30:23] == 8'hFF && t[22:0] != 0) return 0;
    a = single_to_real({1'b0, t[30:0]});
    if (a >= 16.0) begin
      m = 16;
    end else begin
      m = int'($floor(a));
      if (a - m >= 0.5) m++;
    end
    if (t[31] && t[30:0] != 0) m = -m;
    if (m < lo) m = lo;
    if (m > hi) m = hi;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Quantizer model: absorb one weight, queue the results of a closing group
  // ---------------------------------------------------------------------------
  task automatic quantize_weight(input logic [31:0] w, input logic last);
    logic [31:0]   mag;
    logic [31:0]   scale;
    logic [31:0]   recip;
    logic [31:0]   prod;
    real           qmax;
    int            lo;
    int            hi;
    int            bias;
    int            nbits;
    int            code;
    quant_result_t r;
    grp_weights[grp_count] = w;
    grp_count++;
    mag = {1'b0, w[30:0]};
    if (single_to_real(grp_amax) < single_to_real(mag)) grp_amax = mag;
    if (grp_count < GROUP_LEN && !last) return;

    case (cur_mode)
      QT_INT4: begin qmax = 7.0; lo = -8; hi = 7; bias = 8; nbits = 4; end
      QT_INT3: begin qmax = 3.0; lo = -4; hi = 3; bias = 4; nbits = 3; end
      default: begin qmax = 1.0; lo = -2; hi = 1; bias = 2; nbits = 2; end
    endcase

    scale = (single_to_real(grp_amax) > 0.0) ?
            real_to_single(single_to_real(grp_amax) / qmax) : FP_ONE;
    r = '{kind: KIND_SCALE, value: half_of(scale), run_last: 1'b0, tensor_end: 1'b0};
    expected_results.push_back(r);
    // a scale that rounds to zero gives a zero reciprocal
    recip = (single_to_real(scale) > 0.0) ? real_to_single(1.0 / single_to_real(scale)) : '0;

    for (int i = 0; i < grp_count; i++) begin
      prod = real_to_single(single_to_real(grp_weights[i]) * single_to_real(recip));
      code = round_clamp(prod, lo, hi) + bias;
      pack_bits  = pack_bits | 16'(code << pack_count);
      pack_count = pack_count + nbits;
      while (pack_count >= 8) begin
        r = '{kind: KIND_BYTE, value: {8'h00, pack_bits[7:0]}, run_last: 1'b0,
              tensor_end: 1'b0};
        expected_results.push_back(r);
        pack_bits  = pack_bits >> 8;
        pack_count = pack_count - 8;
      end
    end
    grp_count = 0;
    grp_amax  = '0;

    // flush a partial byte at tensor end
    if (last) begin
      if (pack_count > 0) begin
        r = '{kind: KIND_BYTE, value: {8'h00, pack_bits[7:0]}, run_last: 1'b0,
              tensor_end: 1'b0};
        expected_results.push_back(r);
      end
      pack_bits  = '0;
      pack_count = 0;
      expected_results[$].tensor_end = 1'b1;
    end
    pack_bits = pack_bits & 16'h00FF;
    expected_results[$].run_last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one weight after a random gap and hold it until the block takes it
  task automatic send_weight(input logic [31:0] w, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quantize_weight(w, last);
    weights_sent++;
  endtask

  // Drain every expected result, let the block settle, then write the mode
  task automatic write_mode(input logic [1:0] mode);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cur_mode  = mode;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly ordinary magnitudes, with zeros, subnormals and huge values mixed in
  function automatic logic [31:0] random_weight();
    int          pick;
    logic [7:0]  ex;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return {$urandom_range(0, 1) == 1, 31'b0};
      1:       ex = 8'h00;
      2:       ex = 8'($urandom_range(200, 254));
      3:       ex = 8'($urandom_range(1, 40));
      default: ex = 8'($urandom_range(110, 135));
    endcase
    return {1'($urandom_range(0, 1)), ex, 23'($urandom())};
  endfunction

  task automatic send_tensor(input int len);
    for (int i = 0; i < len; i++) send_weight(random_weight(), i == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero group, largest and smallest magnitudes, rounding ties
  task automatic test_edge_values();
    write_mode(QT_INT4);
    send_weight(32'h8000_0000, 1'b1);   // all zero: scale of one
    send_weight(32'h7F7F_FFFF, 1'b1);   // largest finite: scale overflows fp16
    send_weight(32'h0000_0001, 1'b1);   // smallest subnormal: scale underflows
    send_weight(32'hFF7F_FFFF, 1'b0);
    send_weight(32'h0080_0000, 1'b1);
    // amax 7 gives a unit scale, so halves land on ties
    send_weight(32'h40E0_0000, 1'b0);   // 7.0
    send_weight(32'h4060_0000, 1'b0);   // 3.5
    send_weight(32'hC060_0000, 1'b0);   // -3.5
    send_weight(32'h3F00_0000, 1'b0);   // 0.5
    send_weight(32'hBF00_0000, 1'b0);   // -0.5
    send_weight(32'hC0E0_0000, 1'b0);   // -7.0
    send_weight(32'h3EFF_FFFF, 1'b1);   // just below a half
    write_mode(QT_INT2);
    send_weight(32'h3F80_0000, 1'b0);   // 1.0
    send_weight(32'hBF80_0000, 1'b0);
    send_weight(32'h3F00_0000, 1'b1);
  endtask

  // Each mode, including the unused code, on a short tensor and a full group
  task automatic test_modes();
    for (int m = 0; m < 4; m++) begin
      write_mode(2'(m));
      send_tensor(3);
      send_tensor(GROUP_LEN + 5);
    end
  endtask

  // Random tensors of random length under changing modes
  task automatic test_random_tensors();
    int target;
    target = weights_sent + 80;
    while (weights_sent < target) begin
      if ($urandom_range(0, 2) == 0) write_mode(2'($urandom_range(0, 3)));
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) send_tensor($urandom_range(1, 4));
      else                           send_tensor($urandom_range(5, 40));
    end
    no_gaps = 1'b0;
  endtask

  // Stall the receiver for a long stretch while weights keep coming
  task automatic test_backpressure();
    write_mode(QT_INT3);
    rx_hold = 1'b1;
    no_gaps = 1'b1;
    send_tensor(GROUP_LEN + 7);
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready gaps, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    quant_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %h kind %b", out_tdata, out_tuser[0]);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tuser[0] !== exp_r.kind) begin
          $error("item_kind: expected %b, got %b", exp_r.kind, out_tuser[0]);
          error_count++;
        end
        if (out_tdata !== exp_r.value) begin
          $error("out_value: expected %h, got %h", exp_r.value, out_tdata);
          error_count++;
        end
        if (out_tlast !== exp_r.run_last) begin
          $error("run_last: expected %b, got %b", exp_r.run_last, out_tlast);
          error_count++;
        end
        if (out_tuser[1] !== exp_r.tensor_end) begin
          $error("tensor_end: expected %b, got %b", exp_r.tensor_end, out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: give up once nothing has moved for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    grp_count    = 0;
    grp_amax     = '0;
    pack_bits    = '0;
    pack_count   = 0;
    cur_mode     = QT_INT4;
    error_count  = 0;
    idle_cycles  = 0;
    weights_sent = 0;
    rx_hold      = 1'b0;
    no_gaps      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_modes();
    test_backpressure();
    test_random_tensors();

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/gawq_pkg.sv
rtl/core/gawq_fdiv.sv
rtl/core/group_absmax_weight_quantizer.sv
test/testbench.sv
